### design/tcw_pkg.sv
// Package with the types and codes shared by the console writer modules.
package tcw_pkg;

   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_RETURN    = 8'd13;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] ATTR_RESET     = 8'h07;

   typedef struct packed {
      logic        mode;
      logic [7:0]  char_code;
      logic [10:0] read_cell;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_cell;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attribute;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_READ,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_BACKSPACE,
      OP_PLAIN
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  code;
      logic [10:0] cell_index;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PUT,
      BK_MARK,
      BK_BS_MARK,
      BK_SCR_RD,
      BK_SCR_WR,
      BK_FILL,
      BK_DONE
   } bk_state_type;

endpackage

### design/tcw_front.sv
// Front end: accepts items, classifies them and holds them in a two-entry queue.
module tcw_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tcw_pkg::req_type         req_data,
   output tcw_pkg::queue_head_type  head,
   input  tcw_pkg::back_status_type status
);
   import tcw_pkg::*;

   cmd_type    q_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    cls;

   always_comb begin
      cls.code       = req_data.char_code;
      cls.cell_index = req_data.read_cell;
      if (req_data.mode) begin
         cls.op = OP_READ;
      end else begin
         case (req_data.char_code)
            CHAR_NEWLINE:   cls.op = OP_NEWLINE;
            CHAR_RETURN:    cls.op = OP_RETURN;
            CHAR_TAB:       cls.op = OP_TAB;
            CHAR_BACKSPACE: cls.op = OP_BACKSPACE;
            default:        cls.op = OP_PLAIN;
         endcase
      end
   end

   assign req_stall  = (cnt_ff == 2'd2) | status.clearing;
   assign push       = req_valid & ~req_stall;
   assign head.valid = (cnt_ff != 2'd0);
   assign head.cmd   = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = status.pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, status.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

### design/tcw_back.sv
// Back end: owns the screen memory and cursor and carries out queued commands.
module tcw_back #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               attr,
   input  tcw_pkg::queue_head_type  head,
   output tcw_pkg::back_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tcw_pkg::rsp_type         rsp_data
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int LAST  = COLUMNS * (ROWS - 1);
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int LW    = $clog2(COLUMNS);
   localparam int TW    = $clog2(TAB_WIDTH);
   localparam int NW    = $clog2(TAB_WIDTH + 1);
   localparam int BS_PH = (COLUMNS - 1) % TAB_WIDTH;

   logic [7:0] chr_mem [CELLS];
   logic [7:0] atr_mem [CELLS];
   logic [7:0] rd_chr_ff, rd_atr_ff;

   bk_state_type st_ff, st_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [RW-1:0] row_ff, row_in;
   logic [LW-1:0] col_ff, col_in;
   logic [TW-1:0] ph_ff, ph_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic [7:0]    chr_ff, chr_in;
   op_type        op_ff, op_in;
   logic          oor_ff, oor_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          wr_chr, wr_atr, rd_en;
   logic [CW-1:0] wa, ra;
   logic [7:0]    wchr, watr;
   logic [CW-1:0] row_start;
   logic          out_free;

   assign row_start = cur_ff - CW'(col_ff);
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      st_in        = st_ff;
      cur_in       = cur_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      ph_in        = ph_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      chr_in       = chr_ff;
      op_in        = op_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_chr       = 1'b0;
      wr_atr       = 1'b0;
      wa           = cur_ff;
      wchr         = CHAR_SPACE;
      watr         = attr;
      rd_en        = 1'b0;
      ra           = addr_ff + CW'(COLUMNS);
      status.pop      = 1'b0;
      status.clearing = (st_ff == BK_CLEAR);

      case (st_ff)
         BK_CLEAR: begin
            wr_chr = 1'b1;
            wr_atr = 1'b1;
            wa     = addr_ff;
            wchr   = 8'd0;
            watr   = 8'd0;
            if (addr_ff == CW'(CELLS - 1)) begin
               addr_in = '0;
               st_in   = BK_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (head.valid) begin
               status.pop = 1'b1;
               op_in      = head.cmd.op;
               chr_in     = head.cmd.code;
               st_in      = BK_DONE;
               case (head.cmd.op)
                  OP_READ: begin
                     rd_en  = 1'b1;
                     ra     = CW'(head.cmd.cell_index);
                     oor_in = !(32'(head.cmd.cell_index) < 32'(CELLS));
                  end
                  OP_RETURN: begin
                     cur_in = row_start;
                     col_in = '0;
                     ph_in  = '0;
                     wr_atr = 1'b1;
                     wa     = row_start;
                  end
                  OP_NEWLINE: begin
                     col_in = '0;
                     ph_in  = '0;
                     cnt_in = '0;
                     if (row_ff == RW'(ROWS - 1)) begin
                        addr_in = '0;
                        st_in   = BK_SCR_RD;
                     end else begin
                        row_in = row_ff + 1'b1;
                        cur_in = row_start + CW'(COLUMNS);
                        wr_atr = 1'b1;
                        wa     = row_start + CW'(COLUMNS);
                     end
                  end
                  OP_TAB: begin
                     chr_in = CHAR_SPACE;
                     cnt_in = NW'(TAB_WIDTH) - NW'(ph_ff);
                     st_in  = BK_PUT;
                  end
                  OP_PLAIN: begin
                     cnt_in = NW'(1);
                     st_in  = BK_PUT;
                  end
                  OP_BACKSPACE: begin
                     wr_chr = 1'b1;
                     wr_atr = 1'b1;
                     st_in  = BK_BS_MARK;
                     if (cur_ff == '0) begin
                        wa      = '0;
                        addr_in = CW'(1);
                     end else begin
                        wa      = cur_ff - 1'b1;
                        addr_in = cur_ff;
                        cur_in  = cur_ff - 1'b1;
                        if (col_ff == '0) begin
                           col_in = LW'(COLUMNS - 1);
                           row_in = row_ff - 1'b1;
                           ph_in  = TW'(BS_PH);
                        end else begin
                           col_in = col_ff - 1'b1;
                           ph_in  = (ph_ff == '0) ? TW'(TAB_WIDTH - 1) : ph_ff - 1'b1;
                        end
                     end
                  end
                  default: st_in = BK_DONE;
               endcase
            end
         end
         BK_PUT: begin
            wr_chr = 1'b1;
            wr_atr = 1'b1;
            wa     = cur_ff;
            wchr   = chr_ff;
            cnt_in = cnt_ff - 1'b1;
            if (col_ff == LW'(COLUMNS - 1)) begin
               col_in = '0;
               ph_in  = '0;
               if (row_ff == RW'(ROWS - 1)) begin
                  addr_in = '0;
                  st_in   = BK_SCR_RD;
               end else begin
                  row_in = row_ff + 1'b1;
                  cur_in = cur_ff + 1'b1;
                  st_in  = BK_MARK;
               end
            end else begin
               col_in = col_ff + 1'b1;
               ph_in  = (ph_ff == TW'(TAB_WIDTH - 1)) ? '0 : ph_ff + 1'b1;
               cur_in = cur_ff + 1'b1;
               st_in  = BK_MARK;
            end
         end
         BK_MARK: begin
            wr_atr = 1'b1;
            wa     = cur_ff;
            st_in  = (cnt_ff == '0) ? BK_DONE : BK_PUT;
         end
         BK_BS_MARK: begin
            wr_atr = 1'b1;
            wa     = addr_ff;
            st_in  = BK_DONE;
         end
         BK_SCR_RD: begin
            rd_en = 1'b1;
            ra    = addr_ff + CW'(COLUMNS);
            st_in = BK_SCR_WR;
         end
         BK_SCR_WR: begin
            wr_chr = 1'b1;
            wr_atr = 1'b1;
            wa     = addr_ff;
            wchr   = rd_chr_ff;
            watr   = rd_atr_ff;
            addr_in = addr_ff + 1'b1;
            st_in   = (addr_ff == CW'(LAST - 1)) ? BK_FILL : BK_SCR_RD;
         end
         BK_FILL: begin
            wr_chr = 1'b1;
            wr_atr = 1'b1;
            wa     = addr_ff;
            if (addr_ff == CW'(CELLS - 1)) begin
               cur_in = CW'(LAST);
               st_in  = (cnt_ff == '0) ? BK_DONE : BK_PUT;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.cursor_cell    = 11'(cur_ff);
               rsp_data_in.cell_char      = 8'd0;
               rsp_data_in.cell_attribute = 8'd0;
               if (op_ff == OP_READ && !oor_ff) begin
                  rsp_data_in.cell_char      = rd_chr_ff;
                  rsp_data_in.cell_attribute = rd_atr_ff;
               end
               st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_CLEAR;
         cur_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         ph_ff        <= '0;
         cnt_ff       <= '0;
         addr_ff      <= '0;
         op_ff        <= OP_PLAIN;
         oor_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cur_ff       <= cur_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         ph_ff        <= ph_in;
         cnt_ff       <= cnt_in;
         addr_ff      <= addr_in;
         op_ff        <= op_in;
         oor_ff       <= oor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chr_ff      <= chr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_chr) begin
         chr_mem[wa[AW-1:0]] <= wchr;
      end
      if (wr_atr) begin
         atr_mem[wa[AW-1:0]] <= watr;
      end
      if (rd_en) begin
         rd_chr_ff <= chr_mem[ra[AW-1:0]];
         rd_atr_ff <= atr_mem[ra[AW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/text_console_writer.sv
// Top level of the text console writer.
// Each transfer on req is one character to put or one screen cell to read, and
// each produces one transfer on rsp with the cursor cell after the step. Every
// character written takes two steps of the screen memory write port (write the
// cell, then rewrite the attribute at the new cursor), and a tab writes up to
// TAB_WIDTH spaces this way. A scroll walks the memory, reading and then writing
// each moved cell, and then fills the bottom row with spaces. After reset the
// memory is cleared one cell a cycle while req_stall stays high. A two-entry
// queue lets req take new items while the back end is busy and rsp is held.
module text_console_writer #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcw_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcw_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   logic [7:0]      attr_ff;
   queue_head_type  head;
   back_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   tcw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head      (head),
      .status    (status)
   );

   tcw_back #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .attr      (attr_ff),
      .head      (head),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> req_stall)
      else $error("input taken during memory clear");

   a_reset_starts_clear: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input not held off after reset");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CELLS > 2048) || (32'(rsp_data.cursor_cell) < 32'(CELLS)))
      else $error("cursor outside the screen");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> head.valid)
      else $error("queue popped while empty");
`endif

endmodule

### dv/tb_text_console_writer.sv
// Testbench for the text console writer: random and directed transfers checked against a predictor.
`timescale 1ns / 100ps

module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int COLS = 80;
   localparam int ROWCOUNT = 25;
   localparam int TABW = 8;
   localparam int CELLS = COLS * ROWCOUNT;
   localparam int LAST_START = COLS * (ROWCOUNT - 1);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;
   logic req_stall_q = 1'b1;

   text_console_writer u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [15:0] shadow_screen [CELLS];
   int unsigned shadow_cursor;
   logic [7:0] shadow_attr;

   req_type pending_items[$];
   rsp_type expected_rsps[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic void scroll_check();
      if (shadow_cursor < CELLS) return;
      for (int i = 0; i < LAST_START; i++) shadow_screen[i] = shadow_screen[i + COLS];
      for (int i = LAST_START; i < CELLS; i++) shadow_screen[i] = {shadow_attr, CHAR_SPACE};
      shadow_cursor = LAST_START;
   endfunction

   function automatic void mark_cursor_cell();
      if (shadow_cursor < CELLS) shadow_screen[shadow_cursor][15:8] = shadow_attr;
   endfunction

   function automatic void put_char(input logic [7:0] ch);
      if (shadow_cursor < CELLS) shadow_screen[shadow_cursor] = {shadow_attr, ch};
      shadow_cursor++;
      scroll_check();
      mark_cursor_cell();
   endfunction

   function automatic rsp_type console_step(input req_type item);
      rsp_type r;
      int unsigned n;
      r = '0;
      if (item.mode) begin
         if (item.read_cell < CELLS) begin
            r.cell_char = shadow_screen[item.read_cell][7:0];
            r.cell_attribute = shadow_screen[item.read_cell][15:8];
         end
      end else begin
         case (item.char_code)
            CHAR_NEWLINE: begin
               shadow_cursor = (shadow_cursor / COLS + 1) * COLS;
               scroll_check();
               mark_cursor_cell();
            end
            CHAR_RETURN: begin
               shadow_cursor = (shadow_cursor / COLS) * COLS;
               mark_cursor_cell();
            end
            CHAR_TAB: begin
               n = TABW - ((shadow_cursor % COLS) % TABW);
               repeat (n) put_char(CHAR_SPACE);
               mark_cursor_cell();
            end
            CHAR_BACKSPACE: begin
               if (shadow_cursor >= 1) shadow_cursor--;
               put_char(CHAR_SPACE);
               if (shadow_cursor >= 1) shadow_cursor--;
               mark_cursor_cell();
            end
            default: put_char(item.char_code);
         endcase
      end
      r.cursor_cell = shadow_cursor[10:0];
      return r;
   endfunction

   // Driver: inputs change on the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_q) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Accepted request recorded at the rising edge so the driver sees it next falling edge.
   always @(posedge clock) begin
      req_stall_q <= req_stall;
      if (!reset && req_valid && !req_stall)
         expected_rsps.push_back(console_step(req_data));
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_data.cursor_cell, -1);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.cursor_cell !== want.cursor_cell)
               report_mismatch("cursor_cell", rsp_data.cursor_cell, want.cursor_cell);
            if (rsp_data.cell_char !== want.cell_char)
               report_mismatch("cell_char", rsp_data.cell_char, want.cell_char);
            if (rsp_data.cell_attribute !== want.cell_attribute)
               report_mismatch("cell_attribute", rsp_data.cell_attribute, want.cell_attribute);
         end
      end
   end

   function automatic req_type put_item(input logic [7:0] ch);
      req_type t;
      t.mode = 1'b0;
      t.char_code = ch;
      t.read_cell = 11'($urandom_range(2047));
      return t;
   endfunction

   function automatic req_type read_item(input int cell_index);
      req_type t;
      t.mode = 1'b1;
      t.char_code = 8'($urandom_range(255));
      t.read_cell = 11'(cell_index);
      return t;
   endfunction

   function automatic req_type random_item();
      int k;
      k = $urandom_range(99);
      if (k < 25) begin
         if ($urandom_range(9) == 0) return read_item($urandom_range(2047));
         return read_item($urandom_range(CELLS - 1));
      end
      if (k < 33) return put_item(CHAR_NEWLINE);
      if (k < 37) return put_item(CHAR_RETURN);
      if (k < 42) return put_item(CHAR_TAB);
      if (k < 48) return put_item(CHAR_BACKSPACE);
      return put_item(8'($urandom_range(255)));
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (2 * CELLS + 200) @(posedge clock);
   endtask

   task automatic write_attr(input logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_attr = value;
   endtask

   initial begin
      int phase_idle [4] = '{0, 63, 0, 11};
      int phase_stall [4] = '{0, 0, 63, 11};
      logic [7:0] attrs [4] = '{8'h00, 8'hFF, 8'h1E, 8'hA5};
      for (int i = 0; i < CELLS; i++) shadow_screen[i] = '0;
      shadow_cursor = 0;
      shadow_attr = ATTR_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: reads of untouched and out-of-range cells, all controls.
      pending_items.push_back(read_item(0));
      pending_items.push_back(read_item(CELLS - 1));
      pending_items.push_back(read_item(2047));
      pending_items.push_back(put_item(CHAR_BACKSPACE));
      pending_items.push_back(put_item(8'h00));
      pending_items.push_back(put_item(8'hFF));
      pending_items.push_back(put_item(8'h41));
      pending_items.push_back(put_item(CHAR_TAB));
      pending_items.push_back(put_item(CHAR_TAB));
      pending_items.push_back(put_item(CHAR_BACKSPACE));
      pending_items.push_back(put_item(CHAR_RETURN));
      pending_items.push_back(read_item(0));
      pending_items.push_back(read_item(1));
      repeat (ROWCOUNT) pending_items.push_back(put_item(CHAR_NEWLINE));
      pending_items.push_back(read_item(LAST_START));
      pending_items.push_back(read_item(0));
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         write_attr(attrs[p]);
         send_idle_pct = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         for (int i = 0; i < 175; i++) pending_items.push_back(random_item());
         wait_drained();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

### text_console_writer.f
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_writer.sv
dv/tb_text_console_writer.sv
